// ===== src/lkv_pkg.sv =====
// shared types and constants for the lru key/value cache
`default_nettype none
package lkv_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 31;
	localparam int OUT_W = 32;
	localparam int CAP_W = 5;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 2;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 2'd0;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [OUT_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic en;
		logic op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [VAL_W-1:0] value;
	} look_t;

endpackage
`default_nettype wire

// ===== src/lkv_cfg.sv =====
// configuration register file with apb-style access
`default_nettype none
module lkv_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [lkv_pkg::ADDR_W-1:0] paddr,
	input wire logic [lkv_pkg::DATA_W-1:0] pwdata,
	output logic [lkv_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [lkv_pkg::CAP_W-1:0] capacity
);

	logic [lkv_pkg::CAP_W-1:0] cap_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr == lkv_pkg::ADDR_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (wr_en) begin
			cap_q <= pwdata[lkv_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == lkv_pkg::ADDR_CAPACITY) begin
			prdata = {{(lkv_pkg::DATA_W-lkv_pkg::CAP_W){1'b0}}, cap_q};
		end
	end

	assign capacity = cap_q;

endmodule
`default_nettype wire

// ===== src/lkv_store.sv =====
// entry array with parallel key compare and recency rank update
`default_nettype none
module lkv_store #(
	parameter int ENTRIES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [lkv_pkg::CAP_W-1:0] capacity,
	input wire lkv_pkg::req_t req,
	output lkv_pkg::look_t look
);

	localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW0 = $clog2(ENTRIES + 1);
	localparam int CW = (CW0 > lkv_pkg::CAP_W) ? CW0 : lkv_pkg::CAP_W;

	logic [lkv_pkg::KEY_W-1:0] key_q [ENTRIES];
	logic [lkv_pkg::VAL_W-1:0] val_q [ENTRIES];
	logic [AGE_W-1:0] age_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [lkv_pkg::KEY_W-1:0] key_n [ENTRIES];
	logic [lkv_pkg::VAL_W-1:0] val_n [ENTRIES];
	logic [AGE_W-1:0] age_n [ENTRIES];
	logic [ENTRIES-1:0] valid_n;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] keep;
	logic [ENTRIES-1:0] free_sel;
	logic [AGE_W-1:0] old_age;
	logic [lkv_pkg::VAL_W-1:0] hit_val;
	logic [CW-1:0] cap_w;
	logic [CW-1:0] eff_cap;
	logic [CW-1:0] limit;
	logic taken;

	// effective capacity clamped to 1..ENTRIES
	always_comb begin
		cap_w = CW'(capacity);
		if (cap_w == '0) begin
			eff_cap = CW'(1);
		end else if (cap_w > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = cap_w;
		end
		limit = eff_cap - CW'(1);
	end

	always_comb begin
		old_age = '0;
		hit_val = '0;
		taken = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == req.key);
			if (match[i]) begin
				old_age = old_age | age_q[i];
				hit_val = hit_val | val_q[i];
			end
			keep[i] = valid_q[i] && (CW'(age_q[i]) < limit);
			free_sel[i] = !keep[i] && !taken;
			if (!keep[i]) begin
				taken = 1'b1;
			end
		end
	end

	assign look.hit = |match;
	assign look.value = hit_val;

	always_comb begin
		key_n = key_q;
		val_n = val_q;
		age_n = age_q;
		valid_n = valid_q;
		if (req.en && look.hit) begin
			// touch: younger live entries age by one
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && (age_q[i] < old_age)) begin
					age_n[i] = age_q[i] + AGE_W'(1);
				end
				if (match[i]) begin
					age_n[i] = '0;
					if (req.op == lkv_pkg::OP_PUT) begin
						val_n[i] = req.value;
					end
				end
			end
		end else if (req.en && (req.op == lkv_pkg::OP_PUT)) begin
			// insert: evict past capacity, age the rest, fill first free slot
			for (int i = 0; i < ENTRIES; i++) begin
				valid_n[i] = keep[i];
				if (keep[i]) begin
					age_n[i] = age_q[i] + AGE_W'(1);
				end
				if (free_sel[i]) begin
					valid_n[i] = 1'b1;
					key_n[i] = req.key;
					val_n[i] = req.value;
					age_n[i] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_n;
			age_q <= age_n;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_n;
		val_q <= val_n;
	end

endmodule
`default_nettype wire

// ===== src/lru_key_value_cache.sv =====
// top level of the lru key/value cache: input stage, entry store, result register
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   op, key, value
//   out       source     out_valid / out_stall hit, read_value
//   cfg       apb        psel/penable/pready   paddr, pwdata, prdata
//
// one transfer accepted per cycle while in_stall is low; the whole lookup and update runs when
// the input stage is processed, as a parallel key compare and rank update over all entries.
// a get shows its result through the input stage and the result register; a put gives no result.
// reset empties the store and sets capacity to 16.
// in_stall rises only while a get waits in the input stage behind a held result.
`default_nettype none
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic op,
	input wire logic [lkv_pkg::KEY_W-1:0] key,
	input wire logic [lkv_pkg::VAL_W-1:0] value,
	output logic out_valid,
	input wire logic out_stall,
	output logic hit,
	output logic signed [lkv_pkg::OUT_W-1:0] read_value,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [lkv_pkg::ADDR_W-1:0] paddr,
	input wire logic [lkv_pkg::DATA_W-1:0] pwdata,
	output logic [lkv_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	logic [lkv_pkg::CAP_W-1:0] capacity;
	logic valid_s1;
	logic op_s1;
	logic [lkv_pkg::KEY_W-1:0] key_s1;
	logic [lkv_pkg::VAL_W-1:0] value_s1;
	logic out_valid_q;
	logic hit_q;
	logic [lkv_pkg::OUT_W-1:0] read_value_q;
	logic proc;
	logic load;
	lkv_pkg::req_t req;
	lkv_pkg::look_t look;

	lkv_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.capacity(capacity)
	);

	assign proc = valid_s1 && ((op_s1 == lkv_pkg::OP_PUT) || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !proc;
	assign load = in_valid && !in_stall;

	assign req.en = proc;
	assign req.op = op_s1;
	assign req.key = key_s1;
	assign req.value = value_s1;

	lkv_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.capacity(capacity),
		.req(req),
		.look(look)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1 <= op;
			key_s1 <= key;
			value_s1 <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && (op_s1 == lkv_pkg::OP_GET)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && (op_s1 == lkv_pkg::OP_GET)) begin
			hit_q <= look.hit;
			read_value_q <= look.hit ? {1'b0, look.value} : lkv_pkg::MISS_VALUE;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign read_value = read_value_q;

endmodule
`default_nettype wire
